// File: src/arpe_pkg.sv
package arpe_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEDS_W = 4;
   localparam int COUNT_W = 15;
   localparam int GAIN_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 15;
   localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;

   localparam int MIN_LEN = 8;
   localparam int SAMPLE_COUNT_RST = 16384;
   localparam logic [GAIN_W-1:0] ECHO_GAIN_RST = 9'd205;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_GAIN = 2'd2;

   typedef enum logic [1:0] {
      R_IDLE,
      R_WAIT,
      R_LOAD,
      R_RUN
   } arpe_refresh_type;

   // per-word control that travels with the memory reads
   typedef struct packed {
      logic valid;
      logic tx_on;
      logic echo_on;
      logic [LEDS_W-1:0] leds;
      logic kept;
      logic done;
   } arpe_tag_type;

endpackage

// File: src/arpe_ram.sv
module arpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic clock,
   input  logic en,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

// File: src/arpe_rem.sv
module arpe_rem #(
   parameter int W = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic done,
   output logic [W-1:0] remainder
);

   localparam int CNT_W = $clog2(W + 1);

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0] dvd_ff, dvd_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic [W:0] r_ff, r_in;
   logic [W:0] r_shift;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      r_in = r_ff;
      r_shift = {r_ff[W-1:0], dvd_ff[W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(W);
         dvd_in = dividend;
         dvs_in = divisor;
         r_in = '0;
      end else if (run_ff) begin
         r_in = (r_shift >= {1'b0, dvs_ff}) ? r_shift - {1'b0, dvs_ff} : r_shift;
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign remainder = r_ff[W-1:0];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (dvs_ff == '0 || r_ff < {1'b0, dvs_ff}))
      else $error("remainder not below divisor");

endmodule

// File: src/arpe_mix.sv
module arpe_mix (
   input  logic clock,
   input  logic reset,
   input  arpe_pkg::arpe_tag_type tag_in,
   input  logic [arpe_pkg::GAIN_W-1:0] gain,
   input  logic [arpe_pkg::SAMPLE_W-1:0] a_data,
   input  logic [arpe_pkg::SAMPLE_W-1:0] b_data,
   output logic rsp_strobe,
   output logic signed [arpe_pkg::SAMPLE_W-1:0] rsp_tx_word,
   output logic [arpe_pkg::LEDS_W-1:0] rsp_leds_lit,
   output logic rsp_word_kept,
   output logic rsp_pass_done
);

   import arpe_pkg::*;

   arpe_tag_type tag0_ff, tag1_ff;
   logic [SAMPLE_W-1:0] a1_ff;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [PROD_W-1:0] adj;
   logic signed [PROD_W-1:0] shifted;
   logic [SAMPLE_W-1:0] sum;
   logic [SAMPLE_W-1:0] tx_in;

   logic strobe_ff;
   logic [SAMPLE_W-1:0] tx_ff;
   logic [LEDS_W-1:0] leds_ff;
   logic kept_ff, done_ff;

   assign prod1_in = $signed({1'b0, gain}) * $signed(b_data);

   // scaled echo truncates toward zero, sum wraps at 16 bits
   always_comb begin
      adj = prod1_ff + (prod1_ff[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      shifted = adj >>> 8;
      sum = a1_ff + (tag1_ff.echo_on ? shifted[SAMPLE_W-1:0] : '0);
      tx_in = tag1_ff.tx_on ? sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         tag0_ff <= tag_in;
         tag1_ff <= tag0_ff;
         strobe_ff <= tag1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= a_data;
      prod1_ff <= prod1_in;
      tx_ff <= tx_in;
      leds_ff <= tag1_ff.leds;
      kept_ff <= tag1_ff.kept;
      done_ff <= tag1_ff.done;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_tx_word = tx_ff;
   assign rsp_leds_lit = leds_ff;
   assign rsp_word_kept = kept_ff;
   assign rsp_pass_done = done_ff;

   a_tx_source: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && tx_ff != '0) |-> $past(tag1_ff.tx_on))
      else $error("nonzero word from a silent slot");

endmodule

// File: src/audio_record_playback_echo.sv
// Audio recorder / player with optional echo on playback.
// Input: pulse start with req_mode/req_rx_word while busy is low; the word is
// taken at that edge. req_mode 0 records: of each pair of received words the
// first is stored at the next sample index, the second dropped. req_mode 1
// asks for one playback slot: odd slots give zero, even slots the stored
// sample, plus the gained sample from half a pass earlier in the second half
// when echo is on.
// Output: one result per word, on rsp_* with rsp_strobe high for one cycle,
// registered through tag0, tag1 and the output stage after the accept edge. The receiver has no way to stall.
// Throughput: one word per cycle while busy is low. Both reads of an echo slot
// go out in the accept cycle, to two copies of the sample store that every
// record write updates; the gain multiply and the add each take one register
// stage. csr_* writes take effect at once. A write to sample_count raises busy
// while the LED period phases are rebuilt by two bit-serial remainder units.
// Reset clears positions, LED count and phases and loads the configuration
// defaults; the sample store is not cleared and holds garbage until recorded.
module audio_record_playback_echo #(
   parameter int STORE_DEPTH = 16384,
   parameter int LED_COUNT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_mode,
   input  logic signed [arpe_pkg::SAMPLE_W-1:0] req_rx_word,
   output logic rsp_strobe,
   output logic signed [arpe_pkg::SAMPLE_W-1:0] rsp_tx_word,
   output logic [arpe_pkg::LEDS_W-1:0] rsp_leds_lit,
   output logic rsp_word_kept,
   output logic rsp_pass_done,
   input  logic csr_we,
   input  logic [arpe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [arpe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import arpe_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int SW = AW + 1;
   localparam int CW = SW + 1;
   localparam int LDW = $clog2(LED_COUNT + 1);
   localparam int SH = CW + $clog2(LED_COUNT);
   localparam int MW = SH + 1;
   localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + LED_COUNT - 1) / LED_COUNT);
   localparam int LEN_RST = (SAMPLE_COUNT_RST > STORE_DEPTH) ? STORE_DEPTH : SAMPLE_COUNT_RST;
   localparam int PREC_RST = (LEN_RST / LED_COUNT == 0) ? 1 : LEN_RST / LED_COUNT;
   localparam int PPLAY_RST = (2 * LEN_RST / LED_COUNT == 0) ? 1 : 2 * LEN_RST / LED_COUNT;

   // configuration
   logic [COUNT_W-1:0] sample_count_ff;
   logic echo_en_ff;
   logic [GAIN_W-1:0] echo_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= COUNT_W'(SAMPLE_COUNT_RST);
         echo_en_ff <= 1'b0;
         echo_gain_ff <= ECHO_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ECHO_ENABLE: echo_en_ff <= csr_wdata[0];
            CSR_ECHO_GAIN: echo_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // effective length and LED periods
   logic [CW-1:0] len, len2, half;
   logic [CW+MW-1:0] prec_full, pplay_full;
   logic [CW-1:0] per_rec_ff, per_rec_in, per_play_ff, per_play_in;

   always_comb begin
      if (sample_count_ff < COUNT_W'(MIN_LEN)) begin
         len = CW'(MIN_LEN);
      end else if (sample_count_ff > COUNT_W'(STORE_DEPTH)) begin
         len = CW'(STORE_DEPTH);
      end else begin
         len = CW'(sample_count_ff);
      end
      len2 = {len[CW-2:0], 1'b0};
      half = len >> 1;
   end

   // divide by LED_COUNT through a reciprocal multiply
   assign prec_full = len * RECIP;
   assign pplay_full = len2 * RECIP;
   assign per_rec_in = (prec_full[SH +: CW] == '0) ? CW'(1) : prec_full[SH +: CW];
   assign per_play_in = (pplay_full[SH +: CW] == '0) ? CW'(1) : pplay_full[SH +: CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         per_rec_ff <= CW'(PREC_RST);
         per_play_ff <= CW'(PPLAY_RST);
      end else begin
         per_rec_ff <= per_rec_in;
         per_play_ff <= per_play_in;
      end
   end

   // phase rebuild after a length change
   arpe_refresh_type state_ff, state_in;
   logic rem_start, rec_done, play_done, rem_done;
   logic [CW-1:0] rec_rem, play_rem;

   logic [AW-1:0] rec_idx_ff;
   logic rec_phase_ff;
   logic [SW-1:0] play_slot_ff;
   logic [LDW-1:0] led_ff;
   logic [CW-1:0] rec_mod_ff, play_mod_ff;

   always_comb begin
      state_in = state_ff;
      rem_start = 1'b0;
      unique case (state_ff)
         R_IDLE: ;
         R_WAIT: state_in = R_LOAD;
         R_LOAD: begin
            rem_start = 1'b1;
            state_in = R_RUN;
         end
         R_RUN: if (rem_done) state_in = R_IDLE;
         default: state_in = R_IDLE;
      endcase
      if (csr_we && csr_index == CSR_SAMPLE_COUNT) begin
         state_in = R_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != R_IDLE);
   assign rem_done = rec_done & play_done;

   arpe_rem #(.W(CW)) u_rem_rec (
      .clock(clock), .reset(reset), .start(rem_start),
      .dividend(CW'(rec_idx_ff)), .divisor(per_rec_ff),
      .done(rec_done), .remainder(rec_rem)
   );

   arpe_rem #(.W(CW)) u_rem_play (
      .clock(clock), .reset(reset), .start(rem_start),
      .dividend(CW'(play_slot_ff)), .divisor(per_play_ff),
      .done(play_done), .remainder(play_rem)
   );

   // per-word control, all settled at the accept edge
   logic accept;
   logic [CW-1:0] rec_pos, play_pos, tick_pos, tick_mod;
   logic tick_en;
   logic [LDW-1:0] led_base, led_next, led_item;
   logic rec_last, play_last;
   logic [CW-1:0] rec_mod_step, play_mod_step;
   logic even, echo_on;
   logic [AW-1:0] s_addr, d_addr;
   logic [CW-1:0] d_full;
   logic rec_write;
   arpe_tag_type tag;

   always_comb begin
      accept = start & ~busy;
      rec_pos = CW'(rec_idx_ff);
      play_pos = CW'(play_slot_ff);
      tick_pos = req_mode ? play_pos : rec_pos;
      tick_mod = req_mode ? play_mod_ff : rec_mod_ff;
      tick_en = req_mode | ~rec_phase_ff;
      led_base = (tick_pos == '0) ? '0 : led_ff;
      led_next = (tick_mod == '0 && led_base < LDW'(LED_COUNT)) ? led_base + 1'b1 : led_base;
      led_item = tick_en ? led_next : led_ff;
      rec_last = (rec_pos + CW'(1) >= len);
      play_last = (play_pos + CW'(1) >= len2);
      rec_mod_step = (rec_mod_ff + CW'(1) >= per_rec_ff) ? '0 : rec_mod_ff + CW'(1);
      play_mod_step = (play_mod_ff + CW'(1) >= per_play_ff) ? '0 : play_mod_ff + CW'(1);

      even = ~play_slot_ff[0];
      s_addr = play_slot_ff[SW-1:1];
      echo_on = even & echo_en_ff & (play_pos >= len);
      d_full = (CW'(s_addr) >= half) ? CW'(s_addr) - half : '0;
      d_addr = d_full[AW-1:0];
      rec_write = ~req_mode & ~rec_phase_ff;

      tag.valid = accept;
      tag.tx_on = req_mode & even;
      tag.echo_on = req_mode & echo_on;
      tag.leds = LEDS_W'(led_item);
      tag.kept = rec_write;
      tag.done = req_mode ? play_last : (rec_phase_ff & rec_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_idx_ff <= '0;
         rec_phase_ff <= 1'b0;
         play_slot_ff <= '0;
         led_ff <= '0;
         rec_mod_ff <= '0;
         play_mod_ff <= '0;
      end else if (accept) begin
         if (tick_en) begin
            led_ff <= led_next;
         end
         if (req_mode) begin
            if (play_last) begin
               play_slot_ff <= '0;
               play_mod_ff <= '0;
            end else begin
               play_slot_ff <= play_slot_ff + 1'b1;
               play_mod_ff <= play_mod_step;
            end
         end else if (!rec_phase_ff) begin
            rec_phase_ff <= 1'b1;
         end else begin
            rec_phase_ff <= 1'b0;
            if (rec_last) begin
               rec_idx_ff <= '0;
               rec_mod_ff <= '0;
            end else begin
               rec_idx_ff <= rec_idx_ff + 1'b1;
               rec_mod_ff <= rec_mod_step;
            end
         end
      end else if (state_ff == R_RUN && rem_done) begin
         rec_mod_ff <= rec_rem;
         play_mod_ff <= play_rem;
      end
   end

   // two copies of the store: current sample and delayed sample read in the same cycle
   logic [SAMPLE_W-1:0] a_data, b_data;

   arpe_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store_a (
      .clock(clock),
      .en(accept & (req_mode ? even : ~rec_phase_ff)),
      .we(accept & rec_write),
      .addr(req_mode ? s_addr : rec_idx_ff),
      .wdata(req_rx_word),
      .rdata(a_data)
   );

   arpe_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store_b (
      .clock(clock),
      .en(accept & (req_mode ? echo_on : ~rec_phase_ff)),
      .we(accept & rec_write),
      .addr(req_mode ? d_addr : rec_idx_ff),
      .wdata(req_rx_word),
      .rdata(b_data)
   );

   arpe_mix u_mix (
      .clock(clock),
      .reset(reset),
      .tag_in(tag),
      .gain(echo_gain_ff),
      .a_data(a_data),
      .b_data(b_data),
      .rsp_strobe(rsp_strobe),
      .rsp_tx_word(rsp_tx_word),
      .rsp_leds_lit(rsp_leds_lit),
      .rsp_word_kept(rsp_word_kept),
      .rsp_pass_done(rsp_pass_done)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result without a word accepted three edges before");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_IDLE) |-> (rec_mod_ff < per_rec_ff && play_mod_ff < per_play_ff))
      else $error("LED phase out of period");

   a_led_bound: assert property (@(posedge clock) disable iff (reset)
      led_ff <= LDW'(LED_COUNT))
      else $error("LED count above maximum");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import arpe_pkg::*;

   localparam int STORE_WORDS = 16384;
   localparam int LED_TOTAL = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [SAMPLE_W-1:0] CORNER_WORDS [8] = '{
      16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0] tx;
      logic [LEDS_W-1:0] leds;
      logic kept;
      logic done;
   } audio_result_type;

   typedef struct packed {
      logic mode;
      logic [SAMPLE_W-1:0] rx;
      audio_result_type want;
   } audio_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic signed [SAMPLE_W-1:0] req_rx_word = '0;
   logic rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_tx_word;
   logic [LEDS_W-1:0] rsp_leds_lit;
   logic rsp_word_kept;
   logic rsp_pass_done;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   audio_record_playback_echo u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_rx_word(req_rx_word),
      .rsp_strobe(rsp_strobe),
      .rsp_tx_word(rsp_tx_word),
      .rsp_leds_lit(rsp_leds_lit),
      .rsp_word_kept(rsp_word_kept),
      .rsp_pass_done(rsp_pass_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow of the recorder/player
   logic [SAMPLE_W-1:0] shadow_samples [STORE_WORDS];
   bit sample_written [STORE_WORDS];
   int unsigned rec_pos = 0;
   bit rec_half = 1'b0;
   int unsigned play_pos = 0;
   int unsigned leds_on = 0;
   logic [COUNT_W-1:0] length_reg = COUNT_W'(SAMPLE_COUNT_RST);
   bit echo_on = 1'b0;
   logic [GAIN_W-1:0] gain_reg = ECHO_GAIN_RST;

   audio_word_type words_to_send [$];
   audio_result_type results_due [$];
   int sender_idle = 0;
   int mismatches = 0;
   int words_checked = 0;
   int passes_seen = 0;
   int record_words = 0;
   int play_words = 0;
   int cycles = 0;

   logic start_next;
   audio_word_type on_bus;
   audio_result_type want_now;

   function automatic int unsigned pass_len();
      int unsigned n;
      n = length_reg;
      if (n < MIN_LEN) n = MIN_LEN;
      if (n > STORE_WORDS) n = STORE_WORDS;
      return n;
   endfunction

   function automatic void bump_leds(input int unsigned pos, input int unsigned span);
      int unsigned period;
      period = span / LED_TOTAL;
      if (period == 0) period = 1;
      if (pos == 0) leds_on = 0;
      if (pos % period == 0 && leds_on < LED_TOTAL) leds_on++;
   endfunction

   // gain * sample in Q1.8, truncated toward zero, kept to 16 bits
   function automatic logic [SAMPLE_W-1:0] echo_term(input logic signed [SAMPLE_W-1:0] x);
      int g;
      int xv;
      int p;
      int unsigned m;
      g = gain_reg;
      xv = x;
      p = g * xv;
      m = (p < 0) ? -p : p;
      m = m >> 8;
      if (p < 0) m = 0 - m;
      return m[SAMPLE_W-1:0];
   endfunction

   function automatic bit play_reads_written();
      int unsigned n;
      int unsigned s;
      int unsigned d;
      n = pass_len();
      if (play_pos % 2) return 1'b1;
      s = play_pos / 2;
      if (!sample_written[s % STORE_WORDS]) return 1'b0;
      if (echo_on && play_pos >= n) begin
         d = (s >= n / 2) ? s - n / 2 : 0;
         return sample_written[d % STORE_WORDS];
      end
      return 1'b1;
   endfunction

   function automatic audio_result_type next_audio_result(input logic mode,
                                                          input logic [SAMPLE_W-1:0] rx);
      audio_result_type r;
      int unsigned n;
      int unsigned s;
      int unsigned d;
      int unsigned slot;
      logic [SAMPLE_W-1:0] w;
      n = pass_len();
      r = '0;
      if (!mode) begin
         if (!rec_half) begin
            shadow_samples[rec_pos % STORE_WORDS] = rx;
            sample_written[rec_pos % STORE_WORDS] = 1'b1;
            bump_leds(rec_pos, n);
            r.kept = 1'b1;
            rec_half = 1'b1;
         end else begin
            rec_half = 1'b0;
            if (rec_pos + 1 >= n) begin
               rec_pos = 0;
               r.done = 1'b1;
            end else begin
               rec_pos++;
            end
         end
      end else begin
         slot = play_pos;
         if (slot % 2 == 0) begin
            s = slot / 2;
            w = shadow_samples[s % STORE_WORDS];
            if (echo_on && slot >= n) begin
               d = (s >= n / 2) ? s - n / 2 : 0;
               w = w + echo_term(shadow_samples[d % STORE_WORDS]);
            end
            r.tx = w;
         end
         bump_leds(slot, 2 * n);
         if (slot + 1 >= 2 * n) begin
            play_pos = 0;
            r.done = 1'b1;
         end else begin
            play_pos = slot + 1;
         end
      end
      r.leds = leds_on[LEDS_W-1:0];
      return r;
   endfunction

   // a slot that would read a never-recorded sample becomes a record word
   task automatic queue_word(input logic mode, input logic [SAMPLE_W-1:0] rx);
      audio_word_type wd;
      if (mode && !play_reads_written()) mode = 1'b0;
      wd.mode = mode;
      wd.rx = rx;
      wd.want = next_audio_result(mode, rx);
      words_to_send.push_back(wd);
      if (mode) play_words++;
      else record_words++;
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      while (words_to_send.size() != 0 || start || results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLE_COUNT: length_reg = val[COUNT_W-1:0];
         CSR_ECHO_ENABLE: echo_on = val[0];
         CSR_ECHO_GAIN: gain_reg = val[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // mostly whole record pairs and runs of playback slots, some lone words
   task automatic run_phase(input int unsigned len, input bit echo, input int unsigned g,
                            input int idle, input int n_words, input int play_pct);
      int left;
      int k;
      int run;
      wait_drained();
      csr_write(CSR_SAMPLE_COUNT, len);
      csr_write(CSR_ECHO_ENABLE, echo);
      csr_write(CSR_ECHO_GAIN, g);
      @(negedge clock);
      sender_idle = idle;
      left = n_words;
      while (left > 0) begin
         k = $urandom_range(99);
         if (k < play_pct) begin
            run = $urandom_range(1, 6);
            repeat (run) queue_word(1'b1, rand_sample());
            left -= run;
         end else if (k < play_pct + 5) begin
            queue_word(1'b0, rand_sample());
            left--;
         end else begin
            queue_word(1'b0, rand_sample());
            queue_word(1'b0, rand_sample());
            left -= 2;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         start_next = start;
         if (start && !busy) begin
            results_due.push_back(on_bus.want);
            start_next = 1'b0;
         end
         if (!start_next && words_to_send.size() != 0
               && $urandom_range(99) >= sender_idle) begin
            on_bus = words_to_send.pop_front();
            req_mode <= on_bus.mode;
            req_rx_word <= on_bus.rx;
            start_next = 1'b1;
         end
         start <= start_next;
      end
   end

   function automatic void field_check(input string name, input logic [SAMPLE_W-1:0] want,
                                       input logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            $display("%0t: result word with none expected: tx %0h leds %0d kept %0b done %0b",
                     $time, rsp_tx_word, rsp_leds_lit, rsp_word_kept, rsp_pass_done);
            mismatches++;
         end else begin
            want_now = results_due.pop_front();
            field_check("tx_word", want_now.tx, rsp_tx_word);
            field_check("leds_lit", SAMPLE_W'(want_now.leds), SAMPLE_W'(rsp_leds_lit));
            field_check("word_kept", SAMPLE_W'(want_now.kept), SAMPLE_W'(rsp_word_kept));
            field_check("pass_done", SAMPLE_W'(want_now.done), SAMPLE_W'(rsp_pass_done));
            words_checked++;
            if (rsp_pass_done) passes_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: store corner words, play the first slots
      for (int i = 0; i < 8; i++) queue_word(1'b0, CORNER_WORDS[i]);
      repeat (3) queue_word(1'b1, 16'h0000);
      wait_drained();

      // shrink to the shortest pass mid pass, full gain echo: sums wrap
      csr_write(CSR_SAMPLE_COUNT, MIN_LEN);
      csr_write(CSR_ECHO_ENABLE, 1);
      csr_write(CSR_ECHO_GAIN, 256);
      @(negedge clock);
      queue_word(1'b0, 16'h0001);
      queue_word(1'b0, 16'h7FFF);
      queue_word(1'b0, 16'h5555);
      queue_word(1'b0, 16'h8000);
      queue_word(1'b0, 16'hAAAA);
      queue_word(1'b0, 16'h0000);
      queue_word(1'b0, rand_sample());
      queue_word(1'b0, rand_sample());
      repeat (13) queue_word(1'b1, 16'hFFFF);

      // fill the low store with one full record pass first
      run_phase(128, 1'b1, 205, 0, 256, 0);
      run_phase(16384, 1'b0, 0, 74, 100, 50);
      run_phase(20000, 1'b1, 511, 13, 60, 50);
      run_phase(0, 1'b1, 511, 0, 80, 70);
      run_phase(5, 1'b1, 256, 74, 80, 60);
      run_phase(32, 1'b1, 205, 13, 150, 60);
      run_phase(32767, 1'b0, 1, 0, 40, 50);
      run_phase(100, 1'b1, 128, 0, 150, 55);
      run_phase(9, 1'b0, 300, 74, 60, 50);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("tb_top: %0d record words and %0d playback slots over eleven register settings",
               record_words, play_words);
      $display("tb_top: %0d words checked, %0d passes completed", words_checked, passes_seen);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// File: audio_record_playback_echo.f
src/arpe_pkg.sv
src/arpe_ram.sv
src/arpe_rem.sv
src/arpe_mix.sv
src/audio_record_playback_echo.sv
tb/tb_top.sv
